// ----- design/sfs_pkg.sv -----
// Package for the scroll follow smoother: widths, opcodes and register indexes.
// Used by every module of the block.
package sfs_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int COORD_BITS = 16;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int DEL_BITS   = POS_BITS + 1;
    localparam int SQ_BITS    = 2 * DEL_BITS + 1;
    localparam int ROOT_BITS  = DEL_BITS + 1;
    localparam int SPD_BITS   = 9;
    localparam int SIZE_BITS  = 16;
    localparam int VEL_BITS   = ROOT_BITS;
    localparam int NUM_BITS   = DEL_BITS + VEL_BITS;
    localparam int SPD_DIV    = 60 * 256;
    localparam int ADDR_BITS  = 4;

    // The speed divisor 60 * 256 is 15 * 2^10: a shift by 10, then a reciprocal
    // multiply for the 15 that is exact for every dividend below 2^25.
    localparam int SPD_SHIFT   = 10;
    localparam int RECIP_SHIFT = 29;
    localparam logic [ROOT_BITS-1:0] RECIP_15 = ROOT_BITS'(35791395);

    localparam logic [2:0] OP_MOVE      = 3'd0;
    localparam logic [2:0] OP_MOVE_CTR  = 3'd1;
    localparam logic [2:0] OP_GOTO      = 3'd2;
    localparam logic [2:0] OP_GOTO_CTR  = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    localparam logic [ADDR_BITS-1:0] REG_SPEED  = 4'd0;
    localparam logic [ADDR_BITS-1:0] REG_WIDTH  = 4'd4;
    localparam logic [ADDR_BITS-1:0] REG_HEIGHT = 4'd8;

    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

    typedef struct packed {
        logic [SPD_BITS-1:0]  speed;
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
    } cfg_t;

    // Saturate a wider signed value to the position range.
    function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [DEL_BITS+1:0] v);
        if (v > $signed({{4{1'b0}}, POS_MAX[POS_BITS-2:0]}))
            sat_pos = POS_MAX;
        else if (v < $signed({{4{1'b1}}, POS_MIN[POS_BITS-2:0]}))
            sat_pos = POS_MIN;
        else
            sat_pos = v[POS_BITS-1:0];
    endfunction

endpackage

// ----- design/sfs_cfg.sv -----
// APB-style register file for speed and view size.
// Depends on sfs_pkg.
module sfs_cfg
    import sfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output cfg_t                 cfg
);
    cfg_t cfg_reg;

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed  <= SPD_BITS'(256);
            cfg_reg.width  <= SIZE_BITS'(640);
            cfg_reg.height <= SIZE_BITS'(480);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                REG_SPEED:  cfg_reg.speed  <= pwdata[SPD_BITS-1:0];
                REG_WIDTH:  cfg_reg.width  <= pwdata[SIZE_BITS-1:0];
                REG_HEIGHT: cfg_reg.height <= pwdata[SIZE_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_SPEED:  prdata = 32'(cfg_reg.speed);
            REG_WIDTH:  prdata = 32'(cfg_reg.width);
            REG_HEIGHT: prdata = 32'(cfg_reg.height);
            default:    prdata = 32'd0;
        endcase
    end
endmodule

// ----- design/sfs_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on sfs_pkg.
module sfs_div
    import sfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [NUM_BITS-1:0] den,
    output logic                busy,
    output logic                done,
    output logic [NUM_BITS-1:0] quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [NUM_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [NUM_BITS:0]   trial;

    assign quo  = quo_reg;
    assign busy = busy_reg;
    assign done = busy_reg && (cnt_reg == '0);

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[NUM_BITS-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = NUM_BITS'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[NUM_BITS-1:0];
                    quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end
endmodule

// ----- design/sfs_core.sv -----
// Sequencer for position updates: square, root search and step divides.
// Depends on sfs_pkg and sfs_div.
module sfs_core
    import sfs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   opcode,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [POS_BITS-1:0]   view_x,
    output logic signed [POS_BITS-1:0]   view_y,
    output logic                         arrived
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SQX   = 9'b000000010,
        S_SQY   = 9'b000000100,
        S_ROOT  = 9'b000001000,
        S_SCALE = 9'b000010000,
        S_VEL   = 9'b000100000,
        S_DIVX  = 9'b001000000,
        S_DIVY  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    localparam int RCNT_BITS = $clog2(ROOT_BITS + 1);

    state_t state_reg, state_next;
    logic signed [POS_BITS-1:0] pos_x_reg, pos_y_reg, goal_x_reg, goal_y_reg;
    logic signed [DEL_BITS-1:0] dx_reg, dy_reg;
    logic [SQ_BITS-1:0]   dsq_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [RCNT_BITS-1:0] rcnt_reg;
    logic [ROOT_BITS-1:0] scl_reg;
    logic [VEL_BITS-1:0]  vel_reg;
    logic [DEL_BITS-1:0]  qx_reg;
    logic                 div_start;
    logic [NUM_BITS-1:0]  div_num, div_den, div_quo;
    logic                 div_busy;
    logic                 div_done;

    // Shared multiplier operands.
    logic [ROOT_BITS-1:0]       mul_a, mul_b;
    logic [2*ROOT_BITS-1:0]     mul_p;
    logic [DEL_BITS-1:0]        adx, ady;
    logic [ROOT_BITS-1:0]       trial;
    logic [RCNT_BITS-1:0]       rbit;
    logic signed [COORD_BITS+1:0] cx, cy;
    logic signed [DEL_BITS+1:0] fx, fy;
    logic [SPD_BITS-1:0]        spd;
    logic [VEL_BITS-1:0]        vraw;
    logic [DEL_BITS-1:0]        dqv;
    logic signed [DEL_BITS+1:0] sum_x, sum_y;

    assign adx   = dx_reg[DEL_BITS-1] ? DEL_BITS'(-dx_reg) : dx_reg;
    assign ady   = dy_reg[DEL_BITS-1] ? DEL_BITS'(-dy_reg) : dy_reg;
    assign rbit  = rcnt_reg - 1'b1;
    assign trial = root_reg | (ROOT_BITS'(1) << rbit);

    // One multiplier serves the squares, the root trials, the speed scaling
    // and the numerators of both step divides.
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = ROOT_BITS'(adx);
                mul_b = ROOT_BITS'(adx);
            end
            S_SQY:
            begin
                mul_a = ROOT_BITS'(ady);
                mul_b = ROOT_BITS'(ady);
            end
            S_SCALE:
            begin
                mul_a = root_reg;
                mul_b = ROOT_BITS'(spd);
            end
            S_VEL:
            begin
                mul_a = scl_reg;
                mul_b = RECIP_15;
            end
            S_DIVX:
            begin
                mul_a = div_done ? ROOT_BITS'(ady) : ROOT_BITS'(adx);
                mul_b = vel_reg;
            end
            default:
            begin
                mul_a = trial;
                mul_b = trial;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign spd  = (cfg.speed > SPD_BITS'(256)) ? SPD_BITS'(256) : cfg.speed;
    assign vraw = VEL_BITS'(mul_p >> RECIP_SHIFT);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign view_x    = pos_x_reg;
    assign view_y    = pos_y_reg;
    assign arrived   = (pos_x_reg == goal_x_reg) && (pos_y_reg == goal_y_reg);

    // The x divide starts on the first cycle of S_DIVX, the y divide as x finishes.
    assign div_start = (state_reg == S_DIVX) && (!div_busy || div_done);
    assign div_num   = NUM_BITS'(mul_p);
    assign div_den   = NUM_BITS'(root_reg);
    assign dqv       = div_quo[DEL_BITS-1:0];

    assign sum_x = $signed({{3{pos_x_reg[POS_BITS-1]}}, pos_x_reg}) +
                   (dx_reg[DEL_BITS-1] ? -$signed({2'b00, qx_reg})
                                       : $signed({2'b00, qx_reg}));
    assign sum_y = $signed({{3{pos_y_reg[POS_BITS-1]}}, pos_y_reg}) +
                   (dy_reg[DEL_BITS-1] ? -$signed({2'b00, dqv})
                                       : $signed({2'b00, dqv}));

    sfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        cx = $signed({{2{coord_x[COORD_BITS-1]}}, coord_x});
        cy = $signed({{2{coord_y[COORD_BITS-1]}}, coord_y});
        if (opcode == OP_MOVE_CTR || opcode == OP_GOTO_CTR)
        begin
            cx = cx - $signed({2'b00, cfg.width[SIZE_BITS-1:1]});
            cy = cy - $signed({2'b00, cfg.height[SIZE_BITS-1:1]});
        end
        fx = (DEL_BITS+2)'(cx) <<< FRAC_BITS;
        fy = (DEL_BITS+2)'(cy) <<< FRAC_BITS;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (opcode == OP_TICK) ? S_SQX : S_OUT;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_ROOT;
            S_ROOT:
                if (rcnt_reg == RCNT_BITS'(1) || rcnt_reg == '0)
                    state_next = S_SCALE;
            S_SCALE: state_next = S_VEL;
            S_VEL:
                state_next = (dsq_reg <= SQ_BITS'(1) << (2 * FRAC_BITS)) ? S_OUT : S_DIVX;
            S_DIVX: if (div_done) state_next = S_DIVY;
            S_DIVY: if (div_done) state_next = S_OUT;
            S_OUT:  if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in_valid && opcode <= OP_GOTO_CTR)
            begin
                goal_x_reg <= sat_pos(fx);
                goal_y_reg <= sat_pos(fy);
                if (opcode <= OP_MOVE_CTR)
                begin
                    pos_x_reg <= sat_pos(fx);
                    pos_y_reg <= sat_pos(fy);
                end
            end
            else if (state_reg == S_VEL && dsq_reg <= SQ_BITS'(1) << (2 * FRAC_BITS))
            begin
                pos_x_reg <= goal_x_reg;
                pos_y_reg <= goal_y_reg;
            end
            else if (state_reg == S_DIVY && div_done)
            begin
                pos_x_reg <= sat_pos(sum_x);
                pos_y_reg <= sat_pos(sum_y);
            end
        end
    end

    // Datapath registers; the root search runs one bit per cycle from the top.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dx_reg   <= DEL_BITS'(goal_x_reg) - DEL_BITS'(pos_x_reg);
                dy_reg   <= DEL_BITS'(goal_y_reg) - DEL_BITS'(pos_y_reg);
                root_reg <= '0;
                rcnt_reg <= RCNT_BITS'(ROOT_BITS);
            end
            S_SQX: dsq_reg <= SQ_BITS'(mul_p);
            S_SQY: dsq_reg <= dsq_reg + SQ_BITS'(mul_p);
            S_ROOT:
            begin
                if (rcnt_reg != '0)
                begin
                    if (SQ_BITS'(mul_p) <= dsq_reg && mul_p[2*ROOT_BITS-1:SQ_BITS] == '0)
                        root_reg <= trial;
                    rcnt_reg <= rcnt_reg - 1'b1;
                end
            end
            S_SCALE:
                scl_reg <= mul_p[ROOT_BITS+SPD_SHIFT-1:SPD_SHIFT];
            S_VEL:
                vel_reg <= (vraw < VEL_BITS'(1 << FRAC_BITS)) ? VEL_BITS'(1 << FRAC_BITS) : vraw;
            S_DIVX:
                if (div_done) qx_reg <= dqv;
            default: ;
        endcase
    end
endmodule

// ----- design/scroll_follow_smoother.sv -----
// Top level of the scroll follow smoother: register port plus update sequencer.
// Depends on sfs_pkg, sfs_cfg and sfs_core.
//
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  opcode, coord_x, coord_y
// output    out        out_valid/out_stall view_x, view_y, arrived
// config    in         APB psel/penable   paddr, pwdata, prdata
//
// Move, go-to and unknown items go straight to the output state. A tick loads
// and squares the deltas, runs the bitwise root through the shared multiplier,
// scales the speed and runs two serial divides; a tick that snaps skips the
// divides. Reset clears position and target to zero.
// The block takes no new item until its result is taken; out_stall holds it.
module scroll_follow_smoother
    import sfs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   opcode,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [POS_BITS-1:0]   view_x,
    output logic signed [POS_BITS-1:0]   view_y,
    output logic                         arrived
);
    cfg_t cfg;

    sfs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .view_x    (view_x),
        .view_y    (view_y),
        .arrived   (arrived)
    );
endmodule
